### hdl/ipatv_pkg.sv
// Package for the IP address text validator.
// Holds the character class item, address kind and verdict codes, limits and group checks.
// No dependencies.
package ipatv_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [9:0]  V4_MAX_VALUE    = 10'd255;
    localparam logic [9:0]  VALUE_SATURATED = 10'd1023;
    localparam logic [2:0]  V4_MAX_DIGITS   = 3'd3;
    localparam logic [2:0]  V6_MAX_DIGITS   = 3'd4;
    localparam logic [3:0]  V4_SEPARATORS   = 4'd3;
    localparam logic [3:0]  V6_SEPARATORS   = 4'd7;
    localparam logic [13:0] DECIMAL_SCALE   = 14'd10;

    typedef enum logic [2:0] {
        CH_DOT,
        CH_COLON,
        CH_DIGIT,
        CH_LETTER,
        CH_OTHER
    } t_char_kind;

    typedef enum logic [1:0] {
        KIND_UNDECIDED,
        KIND_V4,
        KIND_V6,
        KIND_REJECTED
    } t_addr_kind;

    typedef enum logic [1:0] {
        VERDICT_NEITHER,
        VERDICT_V4,
        VERDICT_V6
    } t_verdict;

    typedef struct packed {
        t_char_kind kind;
        logic [3:0] digit;
        logic       last;
    } t_char_item;

    function automatic logic v4_group_ok(
        input logic [2:0] digit_count,
        input logic [9:0] group_value,
        input logic       leading_zero
    );
        return (digit_count >= 3'd1) && (digit_count <= V4_MAX_DIGITS) &&
               (group_value <= V4_MAX_VALUE) &&
               !(leading_zero && (digit_count > 3'd1));
    endfunction

    function automatic logic v6_group_ok(input logic [2:0] digit_count);
        return (digit_count >= 3'd1) && (digit_count <= V6_MAX_DIGITS);
    endfunction

endpackage

### hdl/ipatv_front.sv
// Front end: classifies each accepted character and pushes it into the queue.
// Depends on ipatv_pkg.
module ipatv_front (
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_character,
    input  logic                  i_last,
    input  logic                  i_full,
    output logic                  o_push,
    output ipatv_pkg::t_char_item o_item
);

    always_comb begin
        o_item.digit = i_character[3:0];
        o_item.last  = i_last;
        priority if (i_character == 8'h2E) begin
            o_item.kind = ipatv_pkg::CH_DOT;
        end else if (i_character == 8'h3A) begin
            o_item.kind = ipatv_pkg::CH_COLON;
        end else if ((i_character >= 8'h30) && (i_character <= 8'h39)) begin
            o_item.kind = ipatv_pkg::CH_DIGIT;
        end else if (((i_character >= 8'h61) && (i_character <= 8'h66)) ||
                     ((i_character >= 8'h41) && (i_character <= 8'h46))) begin
            o_item.kind = ipatv_pkg::CH_LETTER;
        end else begin
            o_item.kind = ipatv_pkg::CH_OTHER;
        end
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

endmodule

### hdl/ipatv_queue.sv
// Short queue between front and back end.
// Generic width and depth; no package dependency.
module ipatv_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? next_ptr(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? next_ptr(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_mem[r_rd_ptr];
    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);

endmodule

### hdl/ipatv_back.sv
// Back end: tracks address kind, group count and group contents; registers the verdict.
// Depends on ipatv_pkg.
module ipatv_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ipatv_pkg::t_char_item i_item,
    input  logic                  i_avail,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_verdict
);

    ipatv_pkg::t_addr_kind r_kind, n_kind;
    logic [3:0]            r_group_count, n_group_count;
    logic [2:0]            r_digit_count, n_digit_count;
    logic [9:0]            r_group_value, n_group_value;
    logic                  r_leading_zero, n_leading_zero;
    logic                  r_out_valid;
    ipatv_pkg::t_verdict   r_verdict, n_verdict;
    logic [13:0]           w_scaled;

    assign o_pop    = i_avail && (!i_item.last || !r_out_valid || i_ready);
    assign w_scaled = {4'b0, r_group_value} * ipatv_pkg::DECIMAL_SCALE +
                      {10'b0, i_item.digit};

    always_comb begin
        n_kind         = r_kind;
        n_group_count  = r_group_count;
        n_digit_count  = r_digit_count;
        n_group_value  = r_group_value;
        n_leading_zero = r_leading_zero;
        n_verdict      = ipatv_pkg::VERDICT_NEITHER;

        if (r_kind != ipatv_pkg::KIND_REJECTED) begin
            unique case (i_item.kind)
                ipatv_pkg::CH_DOT: begin
                    if ((r_kind == ipatv_pkg::KIND_V6) ||
                        !ipatv_pkg::v4_group_ok(r_digit_count, r_group_value,
                                                r_leading_zero) ||
                        (r_group_count >= ipatv_pkg::V4_SEPARATORS)) begin
                        n_kind = ipatv_pkg::KIND_REJECTED;
                    end else begin
                        n_kind         = ipatv_pkg::KIND_V4;
                        n_group_count  = r_group_count + 1'b1;
                        n_digit_count  = '0;
                        n_group_value  = '0;
                        n_leading_zero = 1'b0;
                    end
                end
                ipatv_pkg::CH_COLON: begin
                    if ((r_kind == ipatv_pkg::KIND_V4) ||
                        !ipatv_pkg::v6_group_ok(r_digit_count) ||
                        (r_group_count >= ipatv_pkg::V6_SEPARATORS)) begin
                        n_kind = ipatv_pkg::KIND_REJECTED;
                    end else begin
                        n_kind         = ipatv_pkg::KIND_V6;
                        n_group_count  = r_group_count + 1'b1;
                        n_digit_count  = '0;
                        n_group_value  = '0;
                        n_leading_zero = 1'b0;
                    end
                end
                ipatv_pkg::CH_DIGIT, ipatv_pkg::CH_LETTER: begin
                    if (((r_kind == ipatv_pkg::KIND_V4) &&
                         (i_item.kind == ipatv_pkg::CH_LETTER)) ||
                        (r_digit_count >= ipatv_pkg::V6_MAX_DIGITS)) begin
                        n_kind = ipatv_pkg::KIND_REJECTED;
                    end else begin
                        if ((r_digit_count == '0) && (i_item.kind == ipatv_pkg::CH_DIGIT) &&
                            (i_item.digit == 4'd0)) begin
                            n_leading_zero = 1'b1;
                        end
                        n_digit_count = r_digit_count + 1'b1;
                        if ((i_item.kind == ipatv_pkg::CH_LETTER) ||
                            (w_scaled > {4'b0, ipatv_pkg::VALUE_SATURATED})) begin
                            n_group_value = ipatv_pkg::VALUE_SATURATED;
                        end else begin
                            n_group_value = w_scaled[9:0];
                        end
                    end
                end
                default: begin
                    n_kind = ipatv_pkg::KIND_REJECTED;
                end
            endcase
        end

        if (i_item.last) begin
            if ((n_kind == ipatv_pkg::KIND_V4) &&
                ipatv_pkg::v4_group_ok(n_digit_count, n_group_value, n_leading_zero) &&
                (n_group_count == ipatv_pkg::V4_SEPARATORS)) begin
                n_verdict = ipatv_pkg::VERDICT_V4;
            end else if ((n_kind == ipatv_pkg::KIND_V6) &&
                         ipatv_pkg::v6_group_ok(n_digit_count) &&
                         (n_group_count == ipatv_pkg::V6_SEPARATORS)) begin
                n_verdict = ipatv_pkg::VERDICT_V6;
            end
            n_kind         = ipatv_pkg::KIND_UNDECIDED;
            n_group_count  = '0;
            n_digit_count  = '0;
            n_group_value  = '0;
            n_leading_zero = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind         <= ipatv_pkg::KIND_UNDECIDED;
            r_group_count  <= '0;
            r_digit_count  <= '0;
            r_group_value  <= '0;
            r_leading_zero <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_kind         <= n_kind;
                r_group_count  <= n_group_count;
                r_digit_count  <= n_digit_count;
                r_group_value  <= n_group_value;
                r_leading_zero <= n_leading_zero;
            end
            if (o_pop && i_item.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.last) begin
            r_verdict <= n_verdict;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_verdict = r_verdict;

endmodule

### hdl/ip_address_text_validator.sv
// The last character is written into the queue; the back end pops it and registers
// the verdict and raises o_valid. Throughput: one character per cycle; the back end
// updates its group state once per cycle and stalls only while a verdict waits on i_ready.
// Reset: i_rst_n synchronous, active low; clears queue, address state and output valid.
// Top level; depends on ipatv_pkg, ipatv_front, ipatv_queue and ipatv_back.
module ip_address_text_validator #(
    parameter int QUEUE_DEPTH = ipatv_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_character,
    input  logic       i_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_verdict
);

    localparam int ITEM_W = $bits(ipatv_pkg::t_char_item);

    ipatv_pkg::t_char_item w_front_item;
    ipatv_pkg::t_char_item w_back_item;
    logic [ITEM_W-1:0]     w_rd_data;
    logic                  w_push;
    logic                  w_pop;
    logic                  w_full;
    logic                  w_empty;

    ipatv_front u_front (
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_character (i_character),
        .i_last      (i_last),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_item      (w_front_item)
    );

    ipatv_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_wr_data (ITEM_W'(w_front_item)),
        .i_pop     (w_pop),
        .o_rd_data (w_rd_data),
        .o_full    (w_full),
        .o_empty   (w_empty)
    );

    assign w_back_item = ipatv_pkg::t_char_item'(w_rd_data);

    ipatv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (w_back_item),
        .i_avail   (!w_empty),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_verdict (o_verdict)
    );

`ifndef SYNTHESIS
    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_verdict != 2'd3))
        else $error("verdict code out of range");

    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_full && w_empty))
        else $error("queue full and empty at once");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_empty && !w_pop) |-> (o_valid && !i_ready))
        else $error("back end stalled without a waiting verdict");

    a_verdict_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_back_item.last) |=> o_valid)
        else $error("last character popped without a verdict");
`endif

endmodule
